### hw/rtl/bdy_pkg.sv
// Shared constants, node word types and helper functions of the buddy allocator.
`default_nettype none

package bdy_pkg;

   // Largest managed region is 2^MemOrderMax units.
   localparam int MemOrderMax = 10;

   // Node indices in heap order, root at 1.
   localparam int NodeW = MemOrderMax + 1;
   // Sibling pairs share one address: nodes 2p and 2p+1 live at pair index p.
   localparam int PairW = MemOrderMax;
   localparam int PairDepth = 1 << PairW;
   // Tree levels, root at level 0.
   localparam int LvlW = $clog2(MemOrderMax + 1);
   // Block orders, including a size order of up to eleven from the request.
   localparam int OrdW = ($clog2(MemOrderMax + 2) > 4) ? $clog2(MemOrderMax + 2) : 4;
   // One bit per block order in the allocated-order summary.
   localparam int MaskW = MemOrderMax + 1;

   // Word fields.
   localparam int SizeW = 11;
   localparam int OffsetW = 10;

   // Register port.
   localparam int CfgOrderW = 4;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;
   localparam logic [CfgOrderW-1:0] MemOrderReset = 4'd10;
   localparam logic CSR_IDX_ORDER = 1'b0;

   // Request kinds.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   typedef enum logic [1:0] {
      ST_FREE  = 2'd0,
      ST_SPLIT = 2'd1,
      ST_ALLOC = 2'd2
   } node_st_type;

   // A node word. For a split node, mf holds one more than the largest free order
   // below it (zero for none) and mask has a bit set for each order that has an
   // allocated block below it. Both fields mean nothing for free or allocated nodes.
   typedef struct packed {
      logic [MaskW-1:0] mask;
      logic [OrdW-1:0]  mf;
      node_st_type      st;
   } node_word_type;

   localparam int NodeWordW = $bits(node_word_type);
   localparam node_word_type FreeWord = '{mask: '0, mf: '0, st: ST_FREE};
   localparam node_word_type AllocWord = '{mask: '0, mf: '0, st: ST_ALLOC};

   typedef struct packed {
      logic            op;
      logic [OrdW-1:0] k;
      logic [OrdW-1:0] order;
   } bdy_cmd_type;

   typedef struct packed {
      logic               ok;
      logic [OffsetW-1:0] offset;
   } bdy_res_type;

   // Order of the smallest power of two that holds the size; zero counts as one.
   function automatic logic [OrdW-1:0] size_order(input logic [SizeW-1:0] size);
      logic [SizeW-1:0] sm1;
      logic [OrdW-1:0]  k;
      sm1 = size - SizeW'(1);
      k = '0;
      if (size > SizeW'(1)) begin
         for (int i = 0; i < SizeW; i++) begin
            if (sm1[i]) begin
               k = OrdW'(i + 1);
            end
         end
      end
      return k;
   endfunction

   // Largest free order plus one under a node of the given order.
   function automatic logic [OrdW-1:0] eff_mf(input node_word_type w,
                                              input logic [OrdW-1:0] ord);
      logic [OrdW-1:0] r;
      case (w.st)
         ST_FREE:  r = ord + OrdW'(1);
         ST_SPLIT: r = w.mf;
         default:  r = '0;
      endcase
      return r;
   endfunction

   // Orders with an allocated block at or under a node of the given order.
   function automatic logic [MaskW-1:0] eff_mask(input node_word_type w,
                                                 input logic [OrdW-1:0] ord);
      logic [MaskW-1:0] r;
      case (w.st)
         ST_SPLIT: r = w.mask;
         ST_ALLOC: r = MaskW'(1) << ord;
         default:  r = '0;
      endcase
      return r;
   endfunction

   function automatic logic mask_bit(input logic [MaskW-1:0] m, input logic [OrdW-1:0] k);
      logic [MaskW-1:0] sh;
      sh = m >> k;
      return sh[0];
   endfunction

   // Unit offset of a node at depth order-k, for blocks of order k.
   function automatic logic [OffsetW-1:0] node_offset(input logic [NodeW-1:0] node,
                                                      input logic [OrdW-1:0]  k,
                                                      input logic [OrdW-1:0]  ord);
      logic [NodeW-1:0] sh;
      logic [NodeW-1:0] keep;
      sh = node << k;
      keep = ~({NodeW{1'b1}} << ord);
      return OffsetW'(sh & keep);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/bdy_req_if.sv
// Request channel: allocate or free words with their size.
`default_nettype none

interface bdy_req_if import bdy_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [SizeW-1:0] req_size;

   modport source (output valid, output req_type, output req_size, input ready);
   modport sink (input valid, input req_type, input req_size, output ready);
endinterface

`default_nettype wire

### hw/rtl/bdy_rsp_if.sv
// Response channel: success flag and block offset words.
`default_nettype none

interface bdy_rsp_if import bdy_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               ok;
   logic [OffsetW-1:0] block_offset;

   modport source (output valid, output ok, output block_offset, input ready);
   modport sink (input valid, input ok, input block_offset, output ready);
endinterface

`default_nettype wire

### hw/rtl/bdy_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module bdy_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [0:Depth-1];
   logic [Width-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### hw/rtl/bdy_engine.sv
// Tree engine: node memories, descent to the target node and summary update back up.
`default_nettype none

module bdy_engine import bdy_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        clear_req,
   input  logic        start,
   input  bdy_cmd_type cmd,
   output logic        ready,
   output logic        res_valid,
   input  logic        res_ack,
   output bdy_res_type res
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DESC,
      S_ASC,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [PairW-1:0]  clr_ff, clr_in;
   logic              op_ff, op_in;
   logic [OrdW-1:0]   k_ff, k_in;
   logic [OrdW-1:0]   order_ff, order_in;
   logic [OrdW-1:0]   depth_ff, depth_in;
   logic [LvlW-1:0]   lvl_ff, lvl_in;
   logic [NodeW-1:0]  node_ff, node_in;
   logic [NodeW-1:0]  tgt_ff, tgt_in;
   logic              infree_ff, infree_in;
   logic              ok_ff, ok_in;
   node_word_type     word_ff, word_in;
   node_word_type     sib_ff [0:MemOrderMax];
   node_word_type     sib_in [0:MemOrderMax];

   // Memory ports.
   logic                 we_even, we_odd;
   logic [PairW-1:0]     wr_addr, rd_addr;
   node_word_type        wr_word;
   logic [NodeWordW-1:0] wr_raw, rd_even_raw, rd_odd_raw;
   node_word_type        rd_even, rd_odd;

   // Descent and ascent datapath.
   logic [OrdW-1:0]  lvl_order;
   logic             at_target;
   node_word_type    probe, chosen, sib;
   logic             fits, go_left;
   logic [NodeW-1:0] node_next;
   logic [OrdW-1:0]  mf_c, mf_s;
   node_word_type    sib_cur;

   // Even nodes in one memory, odd nodes in the other: both children in one read.
   bdy_ram #(.Width(NodeWordW), .Depth(PairDepth)) u_even_ram (
      .clock (clock),
      .we    (we_even),
      .waddr (wr_addr),
      .wdata (wr_raw),
      .raddr (rd_addr),
      .rdata (rd_even_raw)
   );

   bdy_ram #(.Width(NodeWordW), .Depth(PairDepth)) u_odd_ram (
      .clock (clock),
      .we    (we_odd),
      .waddr (wr_addr),
      .wdata (wr_raw),
      .raddr (rd_addr),
      .rdata (rd_odd_raw)
   );

   assign wr_raw = wr_word;
   assign rd_even = node_word_type'(rd_even_raw);
   assign rd_odd = node_word_type'(rd_odd_raw);

   // Level-dependent quantities.
   assign lvl_order = order_ff - OrdW'(lvl_ff);
   assign at_target = (OrdW'(lvl_ff) == depth_ff);

   // At the root only the odd word is the node; below it the left child is probed.
   assign probe = (lvl_ff == '0) ? rd_odd : rd_even;
   assign fits = (op_ff == OP_ALLOC) ? (eff_mf(probe, lvl_order) > k_ff)
                                     : mask_bit(eff_mask(probe, lvl_order), k_ff);
   assign go_left = infree_ff | fits;
   assign node_next = (lvl_ff == '0) ? NodeW'(1) : {node_ff[NodeW-2:0], ~go_left};
   assign chosen = (lvl_ff == '0) ? rd_odd : (go_left ? rd_even : rd_odd);
   assign sib = infree_ff ? FreeWord : (go_left ? rd_odd : rd_even);

   // Parent summary from the updated child and its sibling.
   assign sib_cur = sib_ff[lvl_ff];
   assign mf_c = eff_mf(word_ff, lvl_order);
   assign mf_s = eff_mf(sib_cur, lvl_order);

   assign ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res.ok = ok_ff;
   assign res.offset = ok_ff ? node_offset(tgt_ff, k_ff, order_ff) : '0;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      op_in = op_ff;
      k_in = k_ff;
      order_in = order_ff;
      depth_in = depth_ff;
      lvl_in = lvl_ff;
      node_in = node_ff;
      tgt_in = tgt_ff;
      infree_in = infree_ff;
      ok_in = ok_ff;
      word_in = word_ff;
      sib_in = sib_ff;
      we_even = 1'b0;
      we_odd = 1'b0;
      wr_addr = node_ff[NodeW-1:1];
      wr_word = word_ff;
      rd_addr = '0;

      case (state_ff)
         S_CLEAR: begin
            we_even = 1'b1;
            we_odd = 1'b1;
            wr_addr = clr_ff;
            wr_word = FreeWord;
            clr_in = clr_ff + PairW'(1);
            if (clr_ff == {PairW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in = cmd.op;
               k_in = cmd.k;
               order_in = cmd.order;
               lvl_in = '0;
               infree_in = 1'b0;
               if (cmd.k > cmd.order) begin
                  ok_in = 1'b0;
                  state_in = S_DONE;
               end else begin
                  depth_in = cmd.order - cmd.k;
                  state_in = S_DESC;
               end
            end
         end
         S_DESC: begin
            if ((lvl_ff == '0) && !fits) begin
               ok_in = 1'b0;
               state_in = S_DONE;
            end else begin
               node_in = node_next;
               if (lvl_ff != '0) begin
                  sib_in[lvl_ff] = sib;
               end
               if (at_target) begin
                  tgt_in = node_next;
                  word_in = (op_ff == OP_ALLOC) ? AllocWord : FreeWord;
                  state_in = S_ASC;
               end else begin
                  // Below a free node every block is free: keep to the left edge.
                  if ((op_ff == OP_ALLOC) && (chosen.st == ST_FREE)) begin
                     infree_in = 1'b1;
                  end
                  lvl_in = lvl_ff + LvlW'(1);
                  rd_addr = node_next[PairW-1:0];
               end
            end
         end
         S_ASC: begin
            we_even = ~node_ff[0];
            we_odd = node_ff[0];
            if (lvl_ff == '0) begin
               ok_in = 1'b1;
               state_in = S_DONE;
            end else begin
               // Two free halves merge; otherwise the parent is split.
               if ((word_ff.st == ST_FREE) && (sib_cur.st == ST_FREE)) begin
                  word_in = FreeWord;
               end else begin
                  word_in.st = ST_SPLIT;
                  word_in.mf = (mf_c > mf_s) ? mf_c : mf_s;
                  word_in.mask = eff_mask(word_ff, lvl_order) | eff_mask(sib_cur, lvl_order);
               end
               node_in = node_ff >> 1;
               lvl_in = lvl_ff - LvlW'(1);
            end
         end
         S_DONE: begin
            if (res_ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A region change releases every block.
      if (clear_req) begin
         state_in = S_CLEAR;
         clr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
      end
      op_ff <= op_in;
      k_ff <= k_in;
      order_ff <= order_in;
      depth_ff <= depth_in;
      lvl_ff <= lvl_in;
      node_ff <= node_in;
      tgt_ff <= tgt_in;
      infree_ff <= infree_in;
      ok_ff <= ok_in;
      word_ff <= word_in;
      sib_ff <= sib_in;
   end

   // Outside the clearing pass, at most one node memory is written per cycle.
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR) |-> !(we_even && we_odd))
      else $error("both node memories written outside the clearing pass");

   // The descent never goes below the depth of the requested block size.
   a_desc_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DESC) |-> (OrdW'(lvl_ff) <= depth_ff))
      else $error("descent went below the target depth");

   // A successful result names a node at the target depth.
   a_tgt_depth: assert property (@(posedge clock) disable iff (reset)
      (res_valid && ok_ff) |-> ((tgt_ff >> depth_ff) == NodeW'(1)))
      else $error("target node does not lie at the target depth");

   // The ascent ends at the root and then reports.
   a_asc_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ASC && lvl_ff == '0 && !clear_req) |=> (res_valid && ok_ff))
      else $error("ascent did not end in a successful result");

endmodule

`default_nettype wire

### hw/rtl/buddy_allocator_top.sv
// Top level of the buddy allocator: register port, request intake and response register.
// A word is handled one tree level at a time: one node-memory read per level going down
// to block depth d = order - log2(size), rounded up, then one write per level going up.
// A size too large for the region is answered with no descent, and a word refused at the
// root with no ascent. A new word is taken only after the previous result left the engine.
// After reset, and after every write of memory_order, a clearing pass frees the whole
// tree; no request word is taken until it ends.
`default_nettype none

module buddy_allocator_top import bdy_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   bdy_req_if.sink             req_bus,
   bdy_rsp_if.source           rsp_bus,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [CsrDataW-1:0] pwdata,
   output logic [CsrDataW-1:0] prdata,
   output logic                pready
);

   logic [CfgOrderW-1:0] memory_order_ff, memory_order_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [OffsetW-1:0]   rsp_offset_ff, rsp_offset_in;

   logic                 csr_idx;
   logic                 csr_wr;
   logic                 clear_req;
   logic [OrdW-1:0]      region_ord;
   bdy_cmd_type          cmd;
   bdy_res_type          eng_res;
   logic                 eng_ready, eng_res_valid, eng_ack, start;

   // Register port: writes complete in the access cycle, no wait states.
   assign pready = 1'b1;
   assign csr_idx = paddr[CsrAddrW-1];
   assign csr_wr = psel && penable && pwrite && pready;
   assign clear_req = csr_wr && (csr_idx == CSR_IDX_ORDER);
   assign memory_order_in = clear_req ? pwdata[CfgOrderW-1:0] : memory_order_ff;
   assign prdata = (csr_idx == CSR_IDX_ORDER) ? CsrDataW'(memory_order_ff) : '0;

   // Region order saturates at the largest supported tree.
   assign region_ord = (int'(memory_order_ff) > MemOrderMax) ? OrdW'(MemOrderMax)
                                                             : OrdW'(memory_order_ff);

   // Request intake.
   assign cmd.op = req_bus.req_type;
   assign cmd.k = size_order(req_bus.req_size);
   assign cmd.order = region_ord;
   assign req_bus.ready = eng_ready;
   assign start = req_bus.valid && eng_ready;

   bdy_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .clear_req (clear_req),
      .start     (start),
      .cmd       (cmd),
      .ready     (eng_ready),
      .res_valid (eng_res_valid),
      .res_ack   (eng_ack),
      .res       (eng_res)
   );

   // Response register: takes a finished result whenever it is empty or being drained.
   assign eng_ack = eng_res_valid && (!rsp_valid_ff || rsp_bus.ready);
   assign rsp_valid_in = eng_ack ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   assign rsp_ok_in = eng_ack ? eng_res.ok : rsp_ok_ff;
   assign rsp_offset_in = eng_ack ? eng_res.offset : rsp_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         memory_order_ff <= MemOrderReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         memory_order_ff <= memory_order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ok_ff <= rsp_ok_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.ok = rsp_ok_ff;
   assign rsp_bus.block_offset = rsp_offset_ff;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench of the buddy allocator: directed and random allocate/free traffic.
module tb import bdy_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 1_000_000;
   localparam int TailCycles = 40;
   localparam int PhaseWords = 240;
   localparam logic [CsrAddrW-1:0] ADDR_ORDER = CsrAddrW'(4 * CSR_IDX_ORDER);
   localparam logic [CsrAddrW-1:0] ADDR_SPARE = CsrAddrW'(4);

   logic                clock = 1'b0;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CsrAddrW-1:0] paddr;
   logic [CsrDataW-1:0] pwdata;
   logic [CsrDataW-1:0] prdata;
   logic                pready;

   bdy_req_if req_bus ();
   bdy_rsp_if rsp_bus ();

   // Own copy of the allocation tree, heap order with the root at 1.
   node_st_type          node_tree [1:(1 << NodeW) - 1];
   logic [CfgOrderW-1:0] order_reg;
   int unsigned          live_by_order [0:MemOrderMax];
   bdy_res_type          owed_replies [$];

   int unsigned words_sent = 0;
   int unsigned grants_alloc = 0;
   int unsigned grants_free = 0;
   int unsigned refusals = 0;
   int unsigned faults = 0;
   int unsigned cycles = 0;
   int unsigned stall_left = 0;
   bit          idle_on = 1'b1;
   bit          calm = 1'b0;

   buddy_allocator_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
   end

   // Hard stop in case the block hangs.
   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("Timeout after %0d cycles with %0d words outstanding", cycles,
               owed_replies.size());
      $display("Regression FAIL");
      $finish;
   end

   task automatic note_fault(input string text);
      faults++;
      if (faults <= 10) begin
         $display("Mismatch at cycle %0d: %s", cycles, text);
      end
   endtask

   task automatic clear_tree();
      foreach (node_tree[x]) begin
         node_tree[x] = ST_FREE;
      end
      foreach (live_by_order[x]) begin
         live_by_order[x] = 0;
      end
   endtask

   // Works out the reply to one request and updates the tree copy.
   function automatic bdy_res_type buddy_decide(input logic op, input logic [SizeW-1:0] size);
      int unsigned eff, k, depth, count, node, n, ps, i, j;
      bdy_res_type res;
      res = '0;
      eff = (order_reg > MemOrderMax) ? MemOrderMax : order_reg;
      k = 0;
      while (k < 12 && (1 << k) < size) begin
         k++;
      end
      if (k <= eff) begin
         depth = eff - k;
         count = 1 << depth;
         for (i = 0; i < count; i++) begin
            node = count + i;
            // Walk down: 2 means every ancestor is split, 1 means a free ancestor
            // covers the node, 0 means an allocated ancestor blocks it.
            ps = 2;
            for (j = 0; j < depth; j++) begin
               if (node_tree[node >> (depth - j)] != ST_SPLIT) begin
                  ps = (node_tree[node >> (depth - j)] == ST_FREE) ? 1 : 0;
                  break;
               end
            end
            if (op == OP_ALLOC && (ps == 1 || (ps == 2 && node_tree[node] == ST_FREE))) begin
               for (j = 0; j < depth; j++) begin
                  node_tree[node >> (depth - j)] = ST_SPLIT;
               end
               node_tree[node] = ST_ALLOC;
               live_by_order[k]++;
               res.ok = 1'b1;
               res.offset = OffsetW'(i << k);
               break;
            end
            if (op == OP_FREE && ps == 2 && node_tree[node] == ST_ALLOC) begin
               // Release, then merge upward while the buddy is free and unsplit.
               n = node;
               node_tree[n] = ST_FREE;
               while (n > 1 && node_tree[n ^ 1] == ST_FREE) begin
                  n = n >> 1;
                  node_tree[n] = ST_FREE;
               end
               live_by_order[k]--;
               res.ok = 1'b1;
               res.offset = OffsetW'(i << k);
               break;
            end
         end
      end
      return res;
   endfunction

   // A size that rounds up to exactly 2^kk units; orders past the field give oversize words.
   function automatic logic [SizeW-1:0] size_in_order(input int unsigned kk);
      if (kk == 0) begin
         return SizeW'($urandom_range(0, 1));
      end
      if (kk >= SizeW) begin
         return SizeW'($urandom_range((1 << (SizeW - 1)) + 1, (1 << SizeW) - 1));
      end
      return SizeW'($urandom_range((1 << (kk - 1)) + 1, 1 << kk));
   endfunction

   // Sends one request word, with an occasional gap first, and records its predicted reply.
   task automatic send_word(input logic op, input logic [SizeW-1:0] size);
      bdy_res_type res;
      if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= op;
      req_bus.req_size <= size;
      do @(posedge clock); while (!req_bus.ready);
      res = buddy_decide(op, size);
      owed_replies.push_back(res);
      words_sent++;
      if (!res.ok) begin
         refusals++;
      end else if (op == OP_ALLOC) begin
         grants_alloc++;
      end else begin
         grants_free++;
      end
   endtask

   // Holds the sender back until every reply has come in.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (owed_replies.size() != 0);
   endtask

   task automatic csr_write(input logic [CsrAddrW-1:0] addr, input logic [CsrDataW-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      if (addr == ADDR_ORDER) begin
         order_reg = data[CfgOrderW-1:0];
         clear_tree();
      end
      @(posedge clock);
   endtask

   task automatic check_order_readback();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ADDR_ORDER;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[CfgOrderW-1:0] !== order_reg) begin
         note_fault($sformatf("memory_order read back: expected %0d, got %0d", order_reg,
                              prdata[CfgOrderW-1:0]));
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Compare each reply word with the oldest outstanding prediction, and stall at random.
   initial begin : rsp_watch
      bdy_res_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (owed_replies.size() == 0) begin
               note_fault($sformatf("reply ok=%0d offset=%0d with no request outstanding",
                                    rsp_bus.ok, rsp_bus.block_offset));
            end else begin
               want = owed_replies.pop_front();
               if (rsp_bus.ok !== want.ok || rsp_bus.block_offset !== want.offset) begin
                  note_fault($sformatf("reply expected ok=%0d offset=%0d, got ok=%0d offset=%0d",
                                       want.ok, want.offset, rsp_bus.ok,
                                       rsp_bus.block_offset));
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic apply_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      order_reg = MemOrderReset;
      clear_tree();
   endtask

   // Rounding, zero size, splitting, merging, oversize, no room and nothing to free.
   task automatic test_first_words();
      send_word(OP_ALLOC, 0);
      send_word(OP_ALLOC, 1);
      send_word(OP_ALLOC, 3);
      send_word(OP_ALLOC, 512);
      send_word(OP_ALLOC, 1024);
      send_word(OP_ALLOC, 2047);
      send_word(OP_FREE, 2047);
      send_word(OP_FREE, 1024);
      send_word(OP_FREE, 0);
      send_word(OP_FREE, 1);
      send_word(OP_FREE, 4);
      send_word(OP_FREE, 512);
      send_word(OP_ALLOC, 682);
      send_word(OP_FREE, 1024);
   endtask

   // Smallest region, and an order above the maximum that must saturate.
   task automatic test_region_orders();
      wait_drained();
      csr_write(ADDR_ORDER, CsrDataW'(0));
      check_order_readback();
      send_word(OP_ALLOC, 1);
      send_word(OP_ALLOC, 1);
      send_word(OP_ALLOC, 2);
      send_word(OP_FREE, 0);
      wait_drained();
      csr_write(ADDR_ORDER, {(CsrDataW - CfgOrderW)'($urandom), CfgOrderW'(15)});
      check_order_readback();
      send_word(OP_ALLOC, 1024);
      send_word(OP_FREE, 1000);
   endtask

   // A write to an unused register must leave the live blocks alone.
   task automatic test_spare_register();
      send_word(OP_ALLOC, 8);
      send_word(OP_ALLOC, 5);
      wait_drained();
      csr_write(ADDR_SPARE, '1);
      check_order_readback();
      send_word(OP_FREE, 7);
      send_word(OP_FREE, 8);
   endtask

   // Random traffic over several region sizes, alternating fill and drain stretches.
   task automatic test_mixed_traffic();
      logic [CfgOrderW-1:0] phase_orders [8];
      int unsigned          eff, kk, live_total, p, i;
      logic                 op;
      phase_orders = '{4'd10, 4'd3, 4'd15, 4'd6, 4'd1, 4'd10, 4'd8, 4'd10};
      for (p = 0; p < 8; p++) begin
         wait_drained();
         calm = (p == 7);
         csr_write(ADDR_ORDER, {(CsrDataW - CfgOrderW)'($urandom), phase_orders[p]});
         check_order_readback();
         eff = (order_reg > MemOrderMax) ? MemOrderMax : order_reg;
         for (i = 0; i < PhaseWords; i++) begin
            if (i % 60 == 0) begin
               idle_on = ($urandom_range(0, 3) != 0);
            end
            if (i == PhaseWords / 2) begin
               wait_drained();
            end
            live_total = 0;
            for (kk = 0; kk <= MemOrderMax; kk++) begin
               live_total += live_by_order[kk];
            end
            op = ($urandom_range(0, 99) < (((i / 60) % 2 == 0) ? 70 : 30)) ? OP_ALLOC : OP_FREE;
            if (op == OP_FREE && live_total > 0 && $urandom_range(0, 99) < 85) begin
               // Free a block size that is really held, so frees mostly succeed.
               kk = $urandom_range(0, MemOrderMax);
               while (live_by_order[kk] == 0) begin
                  kk = (kk + 1) % (MemOrderMax + 1);
               end
            end else if ($urandom_range(0, 99) < 92) begin
               kk = $urandom_range(0, eff);
               eff = (eff < 1) ? eff : eff;
               kk = (kk < $urandom_range(0, eff)) ? kk : $urandom_range(0, kk);
            end else begin
               kk = $urandom_range(eff, SizeW);
            end
            send_word(op, size_in_order(kk));
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.req_type <= OP_ALLOC;
      req_bus.req_size <= '0;
      apply_reset();
      test_first_words();
      test_region_orders();
      test_spare_register();
      test_mixed_traffic();
      wait_drained();
      repeat (TailCycles) @(posedge clock);
      $display("Covered %0d request words over region orders 0 to 15, saturation included,",
               words_sent);
      $display("with %0d allocations and %0d frees granted and %0d refused; %0d mismatches.",
               grants_alloc, grants_free, refusals, faults);
      if (faults == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
